FILE: rtl/gbn_ack_pkg.sv
// Shared types, constants and ones' complement helpers of the go-back-N receiver.
package gbn_ack_pkg;

   localparam int MAX_PACKET_BYTES = 8192;
   // The position counter saturates at MAX_PACKET_BYTES + 1.
   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 2);
   localparam int HEADER_BYTES = 10;

   localparam logic [15:0] FLAG_ACK = 16'h0002;
   localparam logic [15:0] FLAG_FIN = 16'h0004;
   localparam logic [15:0] FLAG_LAS = 16'h0008;
   localparam logic [15:0] SUM_GOOD = 16'hFFFF;
   localparam logic [15:0] ACK_RESET = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IN_ORDER = 2'd0,
      ST_REPEAT   = 2'd1,
      ST_FIN      = 2'd2,
      ST_TIMEOUT  = 2'd3
   } status_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] reply_ack;
      logic [15:0] reply_checksum;
      logic [15:0] payload_length;
      logic        last_of_file;
   } rsp_item_type;

   // Summary of a packet, valid in the cycle its final byte is processed.
   typedef struct packed {
      logic        done;
      logic        good;
      logic [15:0] seq;
      logic [15:0] flags;
      logic [15:0] length;
   } pkt_summary_type;

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? (s[15:0] + 16'd1) : s[15:0];
   endfunction

   function automatic logic [15:0] reply_sum(input logic [15:0] ack);
      return ~ones_add(ack, FLAG_ACK);
   endfunction

endpackage

FILE: rtl/gbn_ack_assembler.sv
// Byte pairing, running ones' complement sum and header word capture.
module gbn_ack_assembler
   import gbn_ack_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_en,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   input  logic            clear,
   output pkt_summary_type summary
);

   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       pending_ff, pending_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      seq_ff, seq_in;
   logic [15:0]      flags_ff, flags_in;
   logic [15:0]      len_ff, len_in;

   logic [15:0]        word;
   logic [POS_W-2:0]   widx;
   logic [15:0]        sum_new;
   logic [POS_W-1:0]   pos_new;

   always_comb begin
      word       = {data_byte, pending_ff};
      widx       = pos_ff[POS_W-1:1];
      sum_new    = sum_ff;
      pending_in = pending_ff;
      seq_in     = seq_ff;
      flags_in   = flags_ff;
      len_in     = len_ff;
      pos_new    = pos_ff;
      if (byte_en) begin
         if (pos_ff < POS_W'(MAX_PACKET_BYTES)) begin
            if (pos_ff[0]) begin
               sum_new = ones_add(sum_ff, word);
               if (widx == (POS_W-1)'(0)) seq_in = word;
               else if (widx == (POS_W-1)'(2)) flags_in = word;
               else if (widx == (POS_W-1)'(4)) len_in = word;
            end else begin
               pending_in = data_byte;
               if (last_byte) sum_new = ones_add(sum_ff, {8'h00, data_byte});
            end
            pos_new = pos_ff + POS_W'(1);
         end else begin
            pos_new = POS_W'(MAX_PACKET_BYTES + 1);
         end
      end

      summary.done   = byte_en && last_byte;
      summary.good   = (pos_new >= POS_W'(HEADER_BYTES)) &&
                       (pos_new <= POS_W'(MAX_PACKET_BYTES)) && (sum_new == SUM_GOOD);
      summary.seq    = seq_in;
      summary.flags  = flags_in;
      summary.length = len_in;

      // The final byte or a close resets the packet assembly.
      if (clear || (byte_en && last_byte)) begin
         sum_in     = '0;
         pending_in = '0;
         pos_in     = '0;
      end else begin
         sum_in = sum_new;
         pos_in = pos_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         pending_ff <= '0;
         pos_ff     <= '0;
         seq_ff     <= '0;
         flags_ff   <= '0;
         len_ff     <= '0;
      end else begin
         sum_ff     <= sum_in;
         pending_ff <= pending_in;
         pos_ff     <= pos_in;
         seq_ff     <= seq_in;
         flags_ff   <= flags_in;
         len_ff     <= len_in;
      end
   end

endmodule

FILE: rtl/gbn_ack_reply_ctrl.sv
// Acknowledgement decision, sequence tracking, idle timer and close state.
module gbn_ack_reply_ctrl
   import gbn_ack_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            tick_en,
   input  pkt_summary_type summary,
   input  logic [15:0]     idle_timeout_ticks,
   output logic            closed,
   output logic            close_clear,
   output logic            result_valid,
   output rsp_item_type    result
);

   logic [15:0] expected_ff, expected_in;
   logic [15:0] last_ack_ff, last_ack_in;
   logic        complete_ff, complete_in;
   logic        closed_ff, closed_in;
   logic [15:0] idle_ff, idle_in;

   logic [15:0] ack;

   always_comb begin
      expected_in  = expected_ff;
      last_ack_in  = last_ack_ff;
      complete_in  = complete_ff;
      closed_in    = closed_ff;
      idle_in      = idle_ff;
      close_clear  = 1'b0;
      result_valid = 1'b0;
      ack          = last_ack_ff;
      result       = '0;
      result.status = ST_REPEAT;

      if (tick_en && complete_ff) begin
         if (idle_ff >= idle_timeout_ticks) begin
            closed_in     = 1'b1;
            close_clear   = 1'b1;
            result_valid  = 1'b1;
            result.status = ST_TIMEOUT;
         end else begin
            idle_in = idle_ff + 16'd1;
         end
      end else if (summary.done) begin
         result_valid = 1'b1;
         if (summary.good && summary.flags == FLAG_FIN) begin
            ack           = summary.seq + 16'd1;
            last_ack_in   = ack;
            closed_in     = 1'b1;
            result.status = ST_FIN;
         end else if (summary.good && summary.seq == expected_ff) begin
            ack                   = expected_ff;
            last_ack_in           = ack;
            expected_in           = expected_ff + 16'd1;
            result.status         = ST_IN_ORDER;
            result.payload_length = summary.length;
            result.last_of_file   = summary.flags[3];
            if (summary.flags[3]) begin
               complete_in = 1'b1;
               idle_in     = '0;
            end
         end
         result.reply_ack      = ack;
         result.reply_checksum = reply_sum(ack);
      end
   end

   assign closed = closed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
         last_ack_ff <= ACK_RESET;
         complete_ff <= 1'b0;
         closed_ff   <= 1'b0;
         idle_ff     <= '0;
      end else begin
         expected_ff <= expected_in;
         last_ack_ff <= last_ack_in;
         complete_ff <= complete_in;
         closed_ff   <= closed_in;
         idle_ff     <= idle_in;
      end
   end

endmodule

FILE: rtl/gbn_receiver_ack_engine.sv
// Top level of the go-back-N receiver acknowledgement engine.
//
//   Channel  Direction  Handshake            Beat carries
//   req      in         req_valid/req_stall  req_item_type: byte or tick item
//   rsp      out        rsp_valid/rsp_stall  rsp_item_type: one reply per packet or close
//   csr      in         csr_valid/csr_ready  idle_timeout_ticks, 16 bits
//
// An accepted beat is held in an input register and worked on from there; its reply, if any,
// is held in the result register. One beat per cycle while no reply waits under rsp_stall.
// The single rate-setting element is the per-byte ones' complement add in the assembler.
// Reset is synchronous and active high; the timeout register returns to 5000 ticks.
// When a reply waits under rsp_stall the pipeline holds and req_stall is raised only
// while the input register is also occupied.
module gbn_receiver_ack_engine
   import gbn_ack_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;
   logic [15:0]  timeout_ff;

   logic            advance;
   logic            fire;
   logic            closed;
   logic            close_clear;
   logic            result_valid;
   rsp_item_type    result;
   pkt_summary_type summary;

   // The pipeline moves whenever the result register is empty or being emptied.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign fire      = in_valid_ff && advance && !closed;
   assign csr_ready = 1'b1;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? (fire && result_valid) : rsp_valid_ff;

   gbn_ack_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (fire && in_item_ff.req_type == REQ_BYTE),
      .data_byte (in_item_ff.data_byte),
      .last_byte (in_item_ff.last_byte),
      .clear     (close_clear),
      .summary   (summary)
   );

   gbn_ack_reply_ctrl u_reply_ctrl (
      .clock              (clock),
      .reset              (reset),
      .tick_en            (fire && in_item_ff.req_type == REQ_TICK),
      .summary            (summary),
      .idle_timeout_ticks (timeout_ff),
      .closed             (closed),
      .close_clear        (close_clear),
      .result_valid       (result_valid),
      .result             (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_wdata;
         end
      end
      // Payload registers carry no reset.
      if (!req_stall) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
